// File: rtl/aes_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package aes_pkg;

  localparam int RegAddrW = 6;
  localparam logic [RegAddrW-1:0] AddrKeyLen = 6'h00;
  localparam logic [RegAddrW-1:0] AddrDecrypt = 6'h08;
  localparam logic [RegAddrW-1:0] AddrKey0 = 6'h10;
  localparam logic [RegAddrW-1:0] AddrKey1 = 6'h18;
  localparam logic [RegAddrW-1:0] AddrKey2 = 6'h20;
  localparam logic [RegAddrW-1:0] AddrKey3 = 6'h28;

  localparam logic [1:0] KeyLen128 = 2'd0;
  localparam logic [1:0] KeyLen192 = 2'd1;

  function automatic logic [7:0] xt(input logic [7:0] a);
    xt = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gmul(input logic [7:0] a, input logic [3:0] b);
    logic [7:0] p;
    logic [7:0] x;
    p = 8'h00;
    x = a;
    for (int i = 0; i < 4; i++) begin
      if (b[i]) p = p ^ x;
      x = xt(x);
    end
    gmul = p;
  endfunction

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};

  localparam logic [7:0] ISBOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  // Forward round on a 128-bit state, no key add, MixColumns if do_mix; byte 0 in bits 127:120, column-major.
  function automatic logic [127:0] fwd_round(input logic [127:0] s, input logic do_mix);
    logic [7:0] b [16];
    logic [7:0] t [16];
    logic [127:0] r;
    for (int i = 0; i < 16; i++) b[i] = SBOX[s[127-8*i -: 8]];
    for (int row = 0; row < 4; row++)
      for (int c = 0; c < 4; c++) t[row+4*c] = b[row+4*((c+row)%4)];
    for (int c = 0; c < 4; c++)
      for (int row = 0; row < 4; row++)
        r[127-8*(row+4*c) -: 8] = do_mix ?
          (gmul(t[4*c+row], 4'd2) ^ gmul(t[4*c+(row+1)%4], 4'd3) ^
           t[4*c+(row+2)%4] ^ t[4*c+(row+3)%4]) : t[row+4*c];
    fwd_round = r;
  endfunction

  function automatic logic [127:0] inv_shift_sub(input logic [127:0] s);
    logic [7:0] t [16];
    logic [127:0] r;
    for (int row = 0; row < 4; row++)
      for (int c = 0; c < 4; c++) t[row+4*((c+row)%4)] = s[127-8*(row+4*c) -: 8];
    for (int i = 0; i < 16; i++) r[127-8*i -: 8] = ISBOX[t[i]];
    inv_shift_sub = r;
  endfunction

  function automatic logic [127:0] inv_mix(input logic [127:0] s);
    logic [7:0] t [16];
    logic [127:0] r;
    for (int i = 0; i < 16; i++) t[i] = s[127-8*i -: 8];
    for (int c = 0; c < 4; c++)
      for (int row = 0; row < 4; row++)
        r[127-8*(row+4*c) -: 8] =
          gmul(t[4*c+row], 4'd14) ^ gmul(t[4*c+(row+1)%4], 4'd11) ^
          gmul(t[4*c+(row+2)%4], 4'd13) ^ gmul(t[4*c+(row+3)%4], 4'd9);
    inv_mix = r;
  endfunction

endpackage
`default_nettype wire

// File: rtl/aes_key_mem.sv
`timescale 1ns / 1ps
`default_nettype none
module aes_key_mem #(
  parameter int Depth = 60,
  parameter int AddrW = 6
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AddrW-1:0] waddr,
  input  wire logic [127:0]     wdata,
  input  wire logic [AddrW-1:0] raddr,
  output logic      [127:0]     rdata
);
  // One row per round key (four words).
  logic [127:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// File: rtl/aes_block_cipher_ecb.sv
`timescale 1ns / 1ps
`default_nettype none
// AES block cipher, ECB mode, 128/192/256-bit keys.
// Input channel: in_valid/in_stall with block_upper, block_lower and
// message_end_in. Output channel: out_valid/out_stall with result_upper,
// result_lower and message_end_out. One result transaction follows each
// input transaction.
// The user must write keys, length and direction through the APB port
// only while idle; the block itself does not enforce it. A key or length
// write invalidates the round-key schedule; the next block first rebuilds
// it, one 32-bit word per cycle. Round keys live in a 128-bit-wide
// synchronous memory, one row per round. From input to result a block
// passes a read slot, the first key addition with the rounds, and an
// output state. The next round's key is fetched while a round executes.
// One transaction is worked on at a time; the next is accepted in the cycle
// after the result is loaded. While the receiver stalls, the next block
// still runs but then waits for the output register, and in_stall stays
// high. Reset clears the configuration registers, the state, the schedule
// flag and all handshakes; the datapath and memory contents are not cleared.
module aes_block_cipher_ecb #(
  parameter int SCHEDULE_WORDS = 60
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [5:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic      [63:0] prdata,
  output logic             pready,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [63:0] block_upper,
  input  wire logic [63:0] block_lower,
  input  wire logic        message_end_in,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic      [63:0] result_upper,
  output logic      [63:0] result_lower,
  output logic             message_end_out
);
  import aes_pkg::*;

  localparam int Rows = (SCHEDULE_WORDS + 3) / 4;
  localparam int RowW = $clog2(Rows + 1);
  localparam logic [RowW-1:0] RowsLim = RowW'(Rows);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001, ST_EXP = 5'b00010, ST_LOAD = 5'b00100,
    ST_RUN = 5'b01000, ST_OUT = 5'b10000
  } state_t;

  state_t state;
  logic [1:0] key_len;
  logic decrypt;
  logic [63:0] key_reg [4];
  logic ready_flag;

  logic cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_len <= '0;
      decrypt <= 1'b0;
      for (int i = 0; i < 4; i++) key_reg[i] <= '0;
    end else if (cfg_wr) begin
      unique case (paddr)
        AddrKeyLen: key_len <= pwdata[1:0];
        AddrDecrypt: decrypt <= pwdata[0];
        AddrKey0: key_reg[0] <= pwdata;
        AddrKey1: key_reg[1] <= pwdata;
        AddrKey2: key_reg[2] <= pwdata;
        AddrKey3: key_reg[3] <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr)
      AddrKeyLen: prdata = {62'd0, key_len};
      AddrDecrypt: prdata = {63'd0, decrypt};
      AddrKey0: prdata = key_reg[0];
      AddrKey1: prdata = key_reg[1];
      AddrKey2: prdata = key_reg[2];
      AddrKey3: prdata = key_reg[3];
      default: prdata = '0;
    endcase
  end

  logic [3:0] nk;
  logic [3:0] nr;
  always_comb begin
    unique case (key_len)
      KeyLen128: begin nk = 4'd4; nr = 4'd10; end
      KeyLen192: begin nk = 4'd6; nr = 4'd12; end
      default:   begin nk = 4'd8; nr = 4'd14; end
    endcase
  end

  // Key expansion: an 8-word window, one new word per cycle.
  logic [31:0] win [8];
  logic [5:0] widx;
  logic [3:0] wmod;
  logic [7:0] rc;
  logic [31:0] prev, newword, tword;
  logic [127:0] row_acc;
  logic [2:0] top_idx;
  assign top_idx = 3'(nk - 4'd1);

  always_comb begin
    prev = win[top_idx];
    tword = prev;
    if (wmod == 4'd0) tword = sub_word({prev[23:0], prev[31:24]}) ^ {rc, 24'd0};
    else if (nk == 4'd8 && wmod == 4'd4) tword = sub_word(prev);
    newword = win[0] ^ tword;
  end

  // Memory port.
  logic mem_we;
  logic [RowW-1:0] mem_waddr, mem_raddr;
  logic [127:0] mem_wdata, mem_rdata;
  logic [RowW-1:0] round_ctr;
  logic [127:0] st;
  logic mend;
  logic [5:0] total_words;
  assign total_words = {nr, 2'b00} + 6'd4;

  aes_key_mem #(.Depth(Rows), .AddrW(RowW)) u_mem (
    .clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
    .raddr(mem_raddr), .rdata(mem_rdata)
  );

  logic [31:0] cur_word;
  logic [31:0] store_word;
  assign cur_word = (widx < {2'b00, nk}) ?
    (widx[0] ? key_reg[widx[2:1]][31:0] : key_reg[widx[2:1]][63:32]) : newword;
  // Words past the stored schedule are kept as zero.
  assign store_word = ({26'd0, widx} < SCHEDULE_WORDS) ? cur_word : 32'd0;
  assign mem_we = (state == ST_EXP) && (widx[1:0] == 2'd3) &&
                  ({26'd0, widx} < SCHEDULE_WORDS + 3);
  assign mem_waddr = widx[RowW+1:2];
  assign mem_wdata = {row_acc[95:0], store_word};

  logic [RowW-1:0] rd_row;
  assign mem_raddr = rd_row;

  // Rows beyond the memory read as an all-zero round key.
  logic rd_oob;
  logic [127:0] round_key;
  always_ff @(posedge clk) begin
    rd_oob <= (mem_raddr >= RowsLim);
  end
  assign round_key = rd_oob ? '0 : mem_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      ready_flag <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_wr && (paddr == AddrKeyLen || paddr == AddrKey0 || paddr == AddrKey1 ||
                     paddr == AddrKey2 || paddr == AddrKey3))
        ready_flag <= 1'b0;
      if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (state)
        ST_IDLE: if (in_valid) begin
          st <= {block_upper, block_lower};
          mend <= message_end_in;
          widx <= '0;
          wmod <= '0;
          rc <= 8'h01;
          state <= ready_flag ? ST_LOAD : ST_EXP;
          rd_row <= decrypt ? nr[RowW-1:0] : '0;
        end
        ST_EXP: begin
          row_acc <= {row_acc[95:0], store_word};
          // Shift the window so win[0] is always w[i-nk].
          for (int i = 0; i < 7; i++)
            win[i] <= (4'(i) == nk - 4'd1) ? cur_word : win[i+1];
          win[7] <= cur_word;
          if (widx >= {2'b00, nk}) begin
            if (wmod == 4'd0) rc <= xt(rc);
          end
          wmod <= (wmod == nk - 4'd1) ? 4'd0 : wmod + 4'd1;
          widx <= widx + 6'd1;
          if (widx == total_words - 6'd1) begin
            ready_flag <= 1'b1;
            state <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          round_ctr <= '0;
          rd_row <= decrypt ? rd_row - 1'b1 : rd_row + 1'b1;
          state <= ST_RUN;
        end
        ST_RUN: begin
          rd_row <= decrypt ? rd_row - 1'b1 : rd_row + 1'b1;
          round_ctr <= round_ctr + 1'b1;
          if (round_ctr == '0) st <= st ^ round_key;
          else if (!decrypt)
            st <= fwd_round(st, round_ctr != nr[RowW-1:0]) ^ round_key;
          else if (round_ctr != nr[RowW-1:0])
            st <= inv_mix(inv_shift_sub(st) ^ round_key);
          else st <= inv_shift_sub(st) ^ round_key;
          if (round_ctr == nr[RowW-1:0]) state <= ST_OUT;
        end
        ST_OUT: if (!out_valid) begin
          result_upper <= st[127:64];
          result_lower <= st[63:0];
          message_end_out <= mend;
          out_valid <= 1'b1;
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign in_stall = (state != ST_IDLE);

  ap_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN) |-> in_stall) else $error("accept while busy");
  ap_run_ready: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN) |-> ready_flag) else $error("schedule not ready");
  ap_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid) else $error("result dropped");
endmodule
`default_nettype wire

// File: tb/aes_ecb_checker.sv
`timescale 1ns / 1ps
module aes_ecb_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [63:0] block_upper,
  input  logic [63:0] block_lower,
  input  logic        message_end_in,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [63:0] result_upper,
  input  logic [63:0] result_lower,
  input  logic        message_end_out,
  output int          fail_count,
  output int          pending
);
  import aes_pkg::*;

  typedef struct packed {
    logic [63:0] upper;
    logic [63:0] lower;
    logic        msg_end;
  } cipher_block_t;

  cipher_block_t expected_blocks[$];

  logic [7:0]  fwd_sbox [256];
  logic [7:0]  inv_sbox [256];
  logic [1:0]  key_len;
  logic        decrypt;
  logic [63:0] key_words [4];
  logic [31:0] round_keys [60];
  logic [7:0]  st [16];

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    p = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p = p ^ a;
      a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    end
    return p;
  endfunction

  function automatic logic [7:0] rol8(input logic [7:0] v, input int n);
    return (v << n) | (v >> (8 - n));
  endfunction

  function automatic logic [31:0] sbox_word(input logic [31:0] w);
    return {fwd_sbox[w[31:24]], fwd_sbox[w[23:16]], fwd_sbox[w[15:8]], fwd_sbox[w[7:0]]};
  endfunction

  // The S-boxes are derived from the field inverse plus the affine map.
  initial begin
    logic [7:0] inv;
    logic [7:0] s;
    for (int x = 0; x < 256; x++) begin
      inv = 8'h00;
      if (x != 0)
        for (int y = 1; y < 256; y++)
          if (gf_mul(8'(x), 8'(y)) == 8'h01) begin
            inv = 8'(y);
            break;
          end
      s = inv ^ rol8(inv, 1) ^ rol8(inv, 2) ^ rol8(inv, 3) ^ rol8(inv, 4) ^ 8'h63;
      fwd_sbox[x] = s;
      inv_sbox[s] = 8'(x);
    end
  end

  // Length code 3 falls into the 256-bit key.
  function automatic int key_nk();
    return (key_len == KeyLen128) ? 4 : ((key_len == KeyLen192) ? 6 : 8);
  endfunction

  function automatic void expand_schedule();
    int nk;
    int total;
    logic [7:0] rc;
    logic [31:0] t;
    nk = key_nk();
    total = 4 * (nk + 7);
    rc = 8'h01;
    for (int i = 0; i < nk; i++)
      round_keys[i] = i[0] ? key_words[i >> 1][31:0] : key_words[i >> 1][63:32];
    for (int i = nk; i < total; i++) begin
      t = round_keys[i-1];
      if (i % nk == 0) begin
        t = sbox_word({t[23:0], t[31:24]}) ^ {rc, 24'h0};
        rc = gf_mul(rc, 8'h02);
      end else if (nk > 6 && i % nk == 4) begin
        t = sbox_word(t);
      end
      round_keys[i] = round_keys[i-nk] ^ t;
    end
  endfunction

  function automatic void xor_round_key(input int rnd);
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        st[r+4*c] = st[r+4*c] ^ round_keys[4*rnd+c][31-8*r -: 8];
  endfunction

  function automatic void sub_bytes(input bit inverse);
    for (int i = 0; i < 16; i++) st[i] = inverse ? inv_sbox[st[i]] : fwd_sbox[st[i]];
  endfunction

  function automatic void rotate_rows(input bit inverse);
    logic [7:0] t [16];
    t = st;
    for (int r = 0; r < 4; r++)
      for (int c = 0; c < 4; c++)
        if (inverse) st[r+4*((c+r)%4)] = t[r+4*c];
        else st[r+4*c] = t[r+4*((c+r)%4)];
  endfunction

  function automatic void mix_state(input bit inverse);
    logic [7:0] coef [4];
    logic [7:0] col [4];
    logic [7:0] v;
    if (inverse) coef = '{8'd14, 8'd11, 8'd13, 8'd9};
    else coef = '{8'd2, 8'd3, 8'd1, 8'd1};
    for (int c = 0; c < 4; c++) begin
      for (int k = 0; k < 4; k++) col[k] = st[4*c+k];
      for (int r = 0; r < 4; r++) begin
        v = 8'h00;
        for (int k = 0; k < 4; k++) v = v ^ gf_mul(coef[(k+4-r)%4], col[k]);
        st[r+4*c] = v;
      end
    end
  endfunction

  function automatic logic [127:0] aes_transform(input logic [127:0] blk);
    int nr;
    logic [127:0] res;
    expand_schedule();
    nr = key_nk() + 6;
    for (int i = 0; i < 16; i++) st[i] = blk[127-8*i -: 8];
    if (!decrypt) begin
      xor_round_key(0);
      for (int rnd = 1; rnd < nr; rnd++) begin
        sub_bytes(1'b0);
        rotate_rows(1'b0);
        mix_state(1'b0);
        xor_round_key(rnd);
      end
      sub_bytes(1'b0);
      rotate_rows(1'b0);
      xor_round_key(nr);
    end else begin
      xor_round_key(nr);
      for (int rnd = nr - 1; rnd > 0; rnd--) begin
        rotate_rows(1'b1);
        sub_bytes(1'b1);
        xor_round_key(rnd);
        mix_state(1'b1);
      end
      rotate_rows(1'b1);
      sub_bytes(1'b1);
      xor_round_key(0);
    end
    for (int i = 0; i < 16; i++) res[127-8*i -: 8] = st[i];
    return res;
  endfunction

  initial fail_count = 0;
  initial pending = 0;

  always @(posedge clk) begin
    cipher_block_t exp_blk;
    logic [127:0] res;
    if (rst) begin
      key_len <= KeyLen128;
      decrypt <= 1'b0;
      for (int i = 0; i < 4; i++) key_words[i] <= 64'h0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr)
          AddrKeyLen:  key_len <= pwdata[1:0];
          AddrDecrypt: decrypt <= pwdata[0];
          AddrKey0:    key_words[0] <= pwdata;
          AddrKey1:    key_words[1] <= pwdata;
          AddrKey2:    key_words[2] <= pwdata;
          AddrKey3:    key_words[3] <= pwdata;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        res = aes_transform({block_upper, block_lower});
        expected_blocks.push_back('{res[127:64], res[63:0], message_end_in});
      end
      if (out_valid && !out_stall) begin
        if (expected_blocks.size() == 0) begin
          $display("%0t: unexpected result %h %h %b", $time,
                   result_upper, result_lower, message_end_out);
          fail_count++;
        end else begin
          exp_blk = expected_blocks.pop_front();
          if (result_upper !== exp_blk.upper) begin
            $display("%0t: result_upper expected %h actual %h", $time,
                     exp_blk.upper, result_upper);
            fail_count++;
          end
          if (result_lower !== exp_blk.lower) begin
            $display("%0t: result_lower expected %h actual %h", $time,
                     exp_blk.lower, result_lower);
            fail_count++;
          end
          if (message_end_out !== exp_blk.msg_end) begin
            $display("%0t: message_end_out expected %b actual %b", $time,
                     exp_blk.msg_end, message_end_out);
            fail_count++;
          end
        end
      end
      pending <= expected_blocks.size();
    end
  end
endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
module tb;
  import aes_pkg::*;

  // A slow run: about 650 blocks, each possibly rebuilding the schedule
  // before its rounds, with sender gaps and receiver stalls.
  // The limit below is several times what such a run needs.
  localparam int CycleLimit = 600000;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [5:0]  paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic        pready;
  logic        in_valid;
  logic        in_stall;
  logic [63:0] block_upper;
  logic [63:0] block_lower;
  logic        message_end_in;
  logic        out_valid;
  logic        out_stall;
  logic [63:0] result_upper;
  logic [63:0] result_lower;
  logic        message_end_out;
  int          fail_count;
  int          pending;
  int          cycles;
  int          burst_left;

  aes_block_cipher_ecb dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall),
    .block_upper(block_upper), .block_lower(block_lower),
    .message_end_in(message_end_in),
    .out_valid(out_valid), .out_stall(out_stall),
    .result_upper(result_upper), .result_lower(result_lower),
    .message_end_out(message_end_out)
  );

  aes_ecb_checker u_checker (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata),
    .in_valid(in_valid), .in_stall(in_stall),
    .block_upper(block_upper), .block_lower(block_lower),
    .message_end_in(message_end_in),
    .out_valid(out_valid), .out_stall(out_stall),
    .result_upper(result_upper), .result_lower(result_lower),
    .message_end_out(message_end_out),
    .fail_count(fail_count), .pending(pending)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // The watchdog counts cycles and ends a run that hangs.
  initial cycles = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  // The receiver moves through three stall patterns in turn: no stalls,
  // occasional stalls and mostly stalled. Once, early in the run, it holds
  // off for a long stretch so the block fills up and has to stall its input
  // while the sender keeps offering transactions.
  initial out_stall = 1'b0;
  always @(negedge clk) begin
    int mode;
    mode = (cycles / 64) % 3;
    if (cycles >= 2000 && cycles < 2400) out_stall <= 1'b1;
    else if (mode == 0) out_stall <= 1'b0;
    else if (mode == 1) out_stall <= ($urandom_range(0, 3) == 0);
    else out_stall <= ($urandom_range(0, 3) != 0);
  end

  // One register write: a setup phase, then an access phase that ends
  // at the rising edge where pready is high.
  task automatic reg_write(input logic [5:0] addr, input logic [63:0] data);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Offers one block and waits for the transaction. The sender works in
  // bursts; between bursts valid may drop for a random gap.
  task automatic send_block(input logic [63:0] up, input logic [63:0] lo, input logic last);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 10);
    end
    in_valid <= 1'b1;
    block_upper <= up;
    block_lower <= lo;
    message_end_in <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    burst_left--;
  endtask

  // Waits until every expected result has come back, then lets the block
  // settle before the registers are touched.
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  initial begin
    logic [1:0]  klen;
    logic        dec;
    logic [63:0] k [4];
    logic [63:0] onehot;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid = 1'b0;
    block_upper = '0;
    block_lower = '0;
    message_end_in = 1'b0;
    burst_left = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // The first four phases are directed: each key length code including
    // the unused one, both directions, an all-zero and an all-one key,
    // and blocks at the extremes. The rest use random settings.
    for (int phase = 0; phase < 14; phase++) begin
      klen = (phase < 4) ? phase[1:0] : 2'($urandom_range(0, 3));
      dec = (phase < 4) ? phase[0] : 1'($urandom_range(0, 1));
      for (int i = 0; i < 4; i++)
        k[i] = (phase == 0) ? 64'h0 : (phase == 1) ? '1 : rand64();
      reg_write(AddrKeyLen, {62'h0, klen});
      reg_write(AddrDecrypt, {63'h0, dec});
      reg_write(AddrKey0, k[0]);
      reg_write(AddrKey1, k[1]);
      reg_write(AddrKey2, k[2]);
      reg_write(AddrKey3, k[3]);
      if (phase < 4) begin
        onehot = 64'h1 << $urandom_range(0, 63);
        send_block(64'h0, 64'h0, 1'b0);
        send_block('1, '1, 1'b1);
        send_block(64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555, 1'b0);
        send_block(onehot, ~onehot, 1'b1);
        send_block(64'h0011_2233_4455_6677, 64'h8899_aabb_ccdd_eeff, 1'b0);
      end else begin
        // A short run of blocks in one setting, then a key change alone
        // in the middle of the phase once the block is idle.
        for (int n = 0; n < 62; n++) begin
          if (n == 31) begin
            wait_drained();
            reg_write(AddrKey0 + 6'(8 * $urandom_range(0, 3)), rand64());
          end
          send_block(rand64(), rand64(), 1'($urandom_range(0, 1)));
        end
      end
      wait_drained();
    end

    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
